// ===== design/sofp_pkg.sv =====
// ----------------------------------------------------------------------------
// sofp_pkg
// Shared constants and types of the signed offset frame parser.
// ----------------------------------------------------------------------------
package sofp_pkg;

   localparam int FrameBufferSize = 8;
   localparam int CharCountWidth  = $clog2(FrameBufferSize);
   localparam logic [CharCountWidth-1:0] MaxChars = CharCountWidth'(FrameBufferSize - 1);

   localparam int JumpWidth    = 15;
   localparam int TimeoutWidth = 16;
   localparam int CsrDataWidth = 16;
   localparam int CsrIndexWidth = 2;

   localparam logic [CsrIndexWidth-1:0] CsrMaxJump = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrTimeout = 2'd1;

   localparam logic [JumpWidth-1:0]    MaxJumpReset = 15'd30;
   localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd100;

   localparam logic ReqByte = 1'b0;
   localparam logic ReqPoll = 1'b1;

   localparam logic [7:0] CharHeader  = 8'h64;
   localparam logic [7:0] CharNewline = 8'h0a;
   localparam logic [7:0] CharMinus   = 8'h2d;
   localparam logic [7:0] CharZero    = 8'h30;
   localparam logic [7:0] CharNine    = 8'h39;

   typedef struct packed {
      logic                 negative;
      logic [15:0]          accumulator;
      logic [15:0]          filtered;
      logic [JumpWidth-1:0] max_jump;
   } slew_in_type;

endpackage

// ===== design/sofp_req_if.sv =====
// ----------------------------------------------------------------------------
// sofp_req_if
// Request channel: one received byte or one timeout poll.
// ----------------------------------------------------------------------------
interface sofp_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [7:0]  rx_byte;
   logic [31:0] now_ms;

   modport source (output valid, output req_type, output rx_byte, output now_ms,
                   input ready);
   modport sink   (input valid, input req_type, input rx_byte, input now_ms,
                   output ready);
endinterface

// ===== design/sofp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sofp_rsp_if
// Result channel: published offset, update flag and counters.
// ----------------------------------------------------------------------------
interface sofp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] offset_value;
   logic               offset_updated;
   logic [31:0]        last_update_ms;
   logic [15:0]        good_frames;
   logic [15:0]        lost_frames;
   logic [15:0]        bytes_seen;

   modport source (output valid, output offset_value, output offset_updated,
                   output last_update_ms, output good_frames, output lost_frames,
                   output bytes_seen, input ready);
   modport sink   (input valid, input offset_value, input offset_updated,
                   input last_update_ms, input good_frames, input lost_frames,
                   input bytes_seen, output ready);
endinterface

// ===== design/sofp_slew.sv =====
// ----------------------------------------------------------------------------
// sofp_slew
// Applies the sign to the accumulated value and limits its step against
// the previous accepted value.
// ----------------------------------------------------------------------------
module sofp_slew
   import sofp_pkg::*;
(
   input  slew_in_type slew_in,
   output logic [15:0] value_out
);

   logic [15:0]        value;
   logic signed [16:0] diff;
   logic signed [16:0] lim;

   always_comb begin
      value = slew_in.negative ? 16'(16'd0 - slew_in.accumulator) : slew_in.accumulator;
      diff  = 17'(signed'(16'(value - slew_in.filtered)));
      lim   = signed'({2'b00, slew_in.max_jump});
      priority if (diff > lim) begin
         value_out = 16'(slew_in.filtered + {1'b0, slew_in.max_jump});
      end else if (diff < -lim) begin
         value_out = 16'(slew_in.filtered - {1'b0, slew_in.max_jump});
      end else begin
         value_out = value;
      end
   end

endmodule

// ===== design/signed_offset_frame_parser.sv =====
// ----------------------------------------------------------------------------
// signed_offset_frame_parser
// Frame parser for "d[-]digits\n" offset frames with slew limiting.
// ----------------------------------------------------------------------------
// Every request (a received byte or a timeout poll) gives exactly one response
// carrying the published offset and the counters after that request. The parser
// state updates at the accepting edge and the response appears in the output
// register on the next cycle, so one request per cycle is sustained while the
// response side keeps up; the output register holds a stalled response and the
// block takes a new request in the same cycle that the held one is taken.
module signed_offset_frame_parser
   import sofp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   sofp_req_if.sink                 req,
   sofp_rsp_if.source               rsp,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   logic [JumpWidth-1:0]    max_jump_ff;
   logic [TimeoutWidth-1:0] timeout_ff;

   logic                      in_frame_ff, in_frame_in;
   logic [CharCountWidth-1:0] count_ff, count_in;
   logic                      negative_ff, negative_in;
   logic [15:0]               acc_ff, acc_in;
   logic [15:0]               filtered_ff, filtered_in;
   logic [31:0]               header_ff, header_in;
   logic [31:0]               update_ff, update_in;
   logic [15:0]               good_ff, good_in;
   logic [15:0]               lost_ff, lost_in;
   logic [15:0]               bytes_ff, bytes_in;
   logic                      updated_in;

   logic                      rsp_valid_ff;
   logic                      rsp_updated_ff;
   logic [15:0]               rsp_value_ff;
   logic [31:0]               rsp_time_ff;
   logic [15:0]               rsp_good_ff;
   logic [15:0]               rsp_lost_ff;
   logic [15:0]               rsp_bytes_ff;

   logic        accept;
   logic        is_digit;
   logic        is_sign;
   logic [31:0] age;
   logic [15:0] slewed;
   slew_in_type slew_in;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign is_digit = (req.rx_byte >= CharZero) && (req.rx_byte <= CharNine);
   assign is_sign  = (req.rx_byte == CharMinus) && (count_ff == '0);
   assign age      = req.now_ms - header_ff;

   assign slew_in.negative    = negative_ff;
   assign slew_in.accumulator = acc_ff;
   assign slew_in.filtered    = filtered_ff;
   assign slew_in.max_jump    = max_jump_ff;

   sofp_slew u_slew (
      .slew_in   (slew_in),
      .value_out (slewed)
   );

   always_comb begin
      in_frame_in = in_frame_ff;
      count_in    = count_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      filtered_in = filtered_ff;
      header_in   = header_ff;
      update_in   = update_ff;
      good_in     = good_ff;
      lost_in     = lost_ff;
      bytes_in    = bytes_ff;
      updated_in  = 1'b0;
      if (req.req_type == ReqByte) begin
         bytes_in = 16'(bytes_ff + 16'd1);
         priority if (!in_frame_ff) begin
            if (req.rx_byte == CharHeader) begin
               in_frame_in = 1'b1;
               count_in    = '0;
               negative_in = 1'b0;
               acc_in      = '0;
               header_in   = req.now_ms;
            end
         end else if (req.rx_byte == CharNewline) begin
            in_frame_in = 1'b0;
            if (count_ff != '0) begin
               filtered_in = slewed;
               update_in   = req.now_ms;
               good_in     = 16'(good_ff + 16'd1);
               updated_in  = 1'b1;
            end
         end else if (!is_digit && !is_sign) begin
            in_frame_in = 1'b0;
         end else if (count_ff == MaxChars) begin
            in_frame_in = 1'b0;
            lost_in     = 16'(lost_ff + 16'd1);
         end else begin
            if (is_digit) begin
               acc_in = 16'({acc_ff, 3'b000} + {acc_ff, 1'b0} + {8'd0, req.rx_byte - CharZero});
            end else begin
               negative_in = 1'b1;
            end
            count_in = CharCountWidth'(count_ff + 1'b1);
         end
      end else if (in_frame_ff && (age > {16'd0, timeout_ff})) begin
         in_frame_in = 1'b0;
         lost_in     = 16'(lost_ff + 16'd1);
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_jump_ff <= MaxJumpReset;
         timeout_ff  <= TimeoutReset;
      end else if (csr_we) begin
         if (csr_index == CsrMaxJump) begin
            max_jump_ff <= csr_wdata[JumpWidth-1:0];
         end
         if (csr_index == CsrTimeout) begin
            timeout_ff <= csr_wdata[TimeoutWidth-1:0];
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         count_ff    <= '0;
         negative_ff <= 1'b0;
         acc_ff      <= '0;
         filtered_ff <= '0;
         header_ff   <= '0;
         update_ff   <= '0;
         good_ff     <= '0;
         lost_ff     <= '0;
         bytes_ff    <= '0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         count_ff    <= count_in;
         negative_ff <= negative_in;
         acc_ff      <= acc_in;
         filtered_ff <= filtered_in;
         header_ff   <= header_in;
         update_ff   <= update_in;
         good_ff     <= good_in;
         lost_ff     <= lost_in;
         bytes_ff    <= bytes_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_updated_ff <= updated_in;
         rsp_value_ff   <= filtered_in;
         rsp_time_ff    <= update_in;
         rsp_good_ff    <= good_in;
         rsp_lost_ff    <= lost_in;
         rsp_bytes_ff   <= bytes_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.offset_value   = signed'(rsp_value_ff);
   assign rsp.offset_updated = rsp_updated_ff;
   assign rsp.last_update_ms = rsp_time_ff;
   assign rsp.good_frames    = rsp_good_ff;
   assign rsp.lost_frames    = rsp_lost_ff;
   assign rsp.bytes_seen     = rsp_bytes_ff;

endmodule

// ===== design/sofp_checker.sv =====
// ----------------------------------------------------------------------------
// sofp_checker
// Port-level checks of the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module sofp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_offset_updated,
   input logic [15:0] rsp_good_frames,
   input logic [15:0] rsp_bytes_seen
);

   // every accepted request leaves a response in the output register
   a_request_gives_response: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("accepted request gave no response");

   a_reset_clears_response: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   a_response_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("stalled response dropped");

   a_payload_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_offset_updated) && $stable(rsp_good_frames) &&
          $stable(rsp_bytes_seen)))
      else $error("stalled response payload changed");

endmodule

bind signed_offset_frame_parser sofp_checker u_sofp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_offset_updated (rsp.offset_updated),
   .rsp_good_frames    (rsp.good_frames),
   .rsp_bytes_seen     (rsp.bytes_seen)
);
